FILE: design/wsp_pkg.sv
// Shared types and constants for the wheel speed PID block.
package wsp_pkg;

  // Register map
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_LIMIT  = 3'd1,
    REG_KP     = 3'd2,
    REG_KI     = 3'd3,
    REG_KD     = 3'd4
  } cfg_reg_e;

  localparam logic signed [16:0] TARGET_RESET = 17'sd0;
  localparam logic [15:0]        LIMIT_RESET  = 16'd5000;
  localparam logic signed [19:0] KP_RESET     = 20'sd43008;
  localparam logic signed [19:0] KI_RESET     = 20'sd287;
  localparam logic signed [19:0] KD_RESET     = 20'sd0;

  // Fixed point: Q8.12 gains, result scaled down by 2^13
  localparam int DRIVE_SHIFT = 13;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input request
  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } wheel_t;

  // Result
  typedef struct packed {
    logic signed [15:0] drive;
    logic               integral_at_limit;
  } ctrl_t;

  // Configuration registers
  typedef struct packed {
    logic signed [16:0] target_speed_half;
    logic [15:0]        integral_limit;
    logic signed [19:0] kp_gain;
    logic signed [19:0] ki_gain;
    logic signed [19:0] kd_gain;
  } cfg_t;

  // Work handed from front to back
  typedef struct packed {
    logic signed [18:0] err;
    logic signed [17:0] integ;
    logic signed [19:0] diff;
    logic               clamped;
  } wsp_job_t;

endpackage

FILE: design/wheel_speed_pid_with_integral_clamp.sv
// Top level of the wheel speed PID with integral clamp.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   wheel   | wheel_valid, wheel_stall, wheel       | in
//   ctrl    | ctrl_valid, ctrl_stall, ctrl          | out
//   cfg     | cfg_valid, cfg_ready, cfg_index/data  | in
//
// One request per cycle sustained while ctrl_stall stays low; the integral add
// and clamp are combinational in the front. From accept, the front writes the
// queue at the accept edge, then products, sum, and truncate/saturate into the
// output register are each registered in turn.
// Reset clears the integral, previous error, queue and valid bits, and loads
// the register defaults. wheel_stall rises only when the 4-entry queue is full.
module wheel_speed_pid_with_integral_clamp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wheel_valid,
  output logic                             wheel_stall,
  input  wsp_pkg::wheel_t                  wheel,
  output logic                             ctrl_valid,
  input  logic                             ctrl_stall,
  output wsp_pkg::ctrl_t                   ctrl,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data
);
  import wsp_pkg::*;

  cfg_t     cfg;
  wsp_job_t front_job;
  wsp_job_t head_job;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  logic     accept;

  assign cfg_ready   = 1'b1;
  assign wheel_stall = q_full;
  assign accept      = wheel_valid && !wheel_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_speed_half <= TARGET_RESET;
      cfg.integral_limit    <= LIMIT_RESET;
      cfg.kp_gain           <= KP_RESET;
      cfg.ki_gain           <= KI_RESET;
      cfg.kd_gain           <= KD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TARGET: cfg.target_speed_half <= cfg_data[16:0];
        REG_LIMIT:  cfg.integral_limit    <= cfg_data[15:0];
        REG_KP:     cfg.kp_gain           <= cfg_data[19:0];
        REG_KI:     cfg.ki_gain           <= cfg_data[19:0];
        REG_KD:     cfg.kd_gain           <= cfg_data[19:0];
        default:    ;
      endcase
    end
  end

  wsp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .wheel  (wheel),
    .cfg    (cfg),
    .job    (front_job)
  );

  wsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (front_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_job)
  );

  wsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .job_valid  (q_valid),
    .job        (head_job),
    .job_pop    (q_pop),
    .ctrl_valid (ctrl_valid),
    .ctrl_stall (ctrl_stall),
    .ctrl       (ctrl)
  );

endmodule

FILE: design/wsp_front.sv
// Front part: accepts speed requests, updates integral and previous error.
module wsp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  wsp_pkg::wheel_t   wheel,
  input  wsp_pkg::cfg_t     cfg,
  output wsp_pkg::wsp_job_t job
);
  import wsp_pkg::*;

  logic signed [17:0] integ;
  logic signed [18:0] prev_err;

  logic signed [16:0] sum;
  logic signed [18:0] err;
  logic signed [19:0] lim;
  logic signed [19:0] acc;
  logic signed [19:0] acc_clamped;
  logic               clamped;

  // Average as a sum, and the error against target
  assign sum = 17'(wheel.left_speed) + 17'(wheel.right_speed);
  assign err = 19'(cfg.target_speed_half) - 19'(sum);
  assign lim = $signed({3'b000, cfg.integral_limit, 1'b0});

  // Accumulate or clear, then clamp to +/- lim
  always_comb begin
    if (sum != 17'sd0) begin
      acc = 20'(integ) + 20'(err);
    end else begin
      acc = 20'sd0;
    end
    clamped     = 1'b0;
    acc_clamped = acc;
    if (acc > lim) begin
      acc_clamped = lim;
      clamped     = 1'b1;
    end else if (acc < -lim) begin
      acc_clamped = -lim;
      clamped     = 1'b1;
    end
  end

  assign job.err     = err;
  assign job.integ   = acc_clamped[17:0];
  assign job.diff    = 20'(err) - 20'(prev_err);
  assign job.clamped = clamped;

  // Loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      integ    <= '0;
      prev_err <= '0;
    end else if (accept) begin
      integ    <= acc_clamped[17:0];
      prev_err <= err;
    end
  end

endmodule

FILE: design/wsp_queue.sv
// Short register queue between front and back.
module wsp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  wsp_pkg::wsp_job_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output wsp_pkg::wsp_job_t head_data
);
  import wsp_pkg::*;

  wsp_job_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: design/wsp_back.sv
// Back part: gain products, sum, truncate and saturate, output register.
module wsp_back (
  input  logic              clk,
  input  logic              rst,
  input  wsp_pkg::cfg_t     cfg,
  input  logic              job_valid,
  input  wsp_pkg::wsp_job_t job,
  output logic              job_pop,
  output logic              ctrl_valid,
  input  logic              ctrl_stall,
  output wsp_pkg::ctrl_t    ctrl
);
  import wsp_pkg::*;

  localparam int TOT_W = 42;
  localparam int Q_W   = TOT_W - DRIVE_SHIFT;

  // Stage 1: products
  logic               s1_valid;
  logic signed [38:0] prod_p;
  logic signed [37:0] prod_i;
  logic signed [39:0] prod_d;
  logic               s1_clamped;

  // Stage 2: sum
  logic                    s2_valid;
  logic signed [TOT_W-1:0] total;
  logic                    s2_clamped;

  logic out_ready;
  logic s2_ready;
  logic s1_ready;

  logic signed [TOT_W-1:0] biased;
  logic signed [Q_W-1:0]   quot;
  logic signed [15:0]      drive_sat;

  // Stall chain
  assign out_ready = !ctrl_valid || !ctrl_stall;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign job_pop   = job_valid && s1_ready;

  // Truncate toward zero, then saturate to int16
  always_comb begin
    if (total < 0) begin
      biased = total + TOT_W'((1 << DRIVE_SHIFT) - 1);
    end else begin
      biased = total;
    end
    quot = Q_W'(biased >>> DRIVE_SHIFT);
    if (quot > Q_W'(32767)) begin
      drive_sat = 16'sh7fff;
    end else if (quot < -Q_W'(32768)) begin
      drive_sat = -16'sh8000;
    end else begin
      drive_sat = quot[15:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      ctrl_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= job_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (out_ready) begin
        ctrl_valid <= s2_valid;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (job_pop) begin
      prod_p     <= 39'(cfg.kp_gain) * 39'(job.err);
      prod_i     <= 38'(cfg.ki_gain) * 38'(job.integ);
      prod_d     <= 40'(cfg.kd_gain) * 40'(job.diff);
      s1_clamped <= job.clamped;
    end
    if (s2_ready && s1_valid) begin
      total      <= TOT_W'(prod_p) + TOT_W'(prod_i) + TOT_W'(prod_d);
      s2_clamped <= s1_clamped;
    end
    if (out_ready && s2_valid) begin
      ctrl.drive             <= drive_sat;
      ctrl.integral_at_limit <= s2_clamped;
    end
  end

endmodule
